// ===== src/sidd_pkg.sv =====
// Package: shared codes, character constants and result type for the message deframer.
`timescale 1ns / 1ps
`default_nettype none

package sidd_pkg;

    // Deframer phases
    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_HEADER = 2'd1,
        PH_INFO   = 2'd2,
        PH_DATA   = 2'd3
    } phase_t;

    // Result status codes
    localparam logic [2:0] ST_INFO     = 3'd0;
    localparam logic [2:0] ST_DATA     = 3'd1;
    localparam logic [2:0] ST_HDR_BAD  = 3'd2;
    localparam logic [2:0] ST_INFO_BAD = 3'd3;
    localparam logic [2:0] ST_DATA_BAD = 3'd4;

    // Framing characters
    localparam logic [7:0] CH_S     = 8'h53;  // 'S'
    localparam logic [7:0] CH_OPEN  = 8'h7B;  // '{'
    localparam logic [7:0] CH_CLOSE = 8'h7D;  // '}'
    localparam logic [7:0] CH_I     = 8'h49;  // 'I'
    localparam logic [7:0] CH_D     = 8'h44;  // 'D'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

    // Width of the reported size fields
    localparam int SIZE_W = 20;

    // One result transaction
    typedef struct packed {
        logic [2:0]        status;
        logic [7:0]        out_byte;
        logic              part_end;
        logic [SIZE_W-1:0] info_size;
        logic [SIZE_W-1:0] data_size;
    } result_t;

endpackage

`default_nettype wire

// ===== src/sid_message_deframer_top.sv =====
// Top level of the message deframer: input register, core and result register.
//
// Channel  Dir  tdata (low bit up)                            tuser     tlast
// s_axis   in   rx_byte[7:0]                                  -         -
// m_axis   out  out_byte[7:0] info_size[19:0] data_size[19:0] status[2:0] part_end
//
// One byte is taken per cycle while the result register is free; its result,
// if any, is loaded there as the core takes the byte out of the input register.
// Throughput is set by the single per-byte state update in the core.
// aresetn is synchronous and active low; it returns the deframer to hunting.
// While a result waits with m_axis_tready low, the core and input register hold;
// s_axis_tready is low only when the input register is full as well.
`timescale 1ns / 1ps
`default_nettype none

module sid_message_deframer_top #(
    parameter int LEN_DIGITS = 6
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // rx_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // out_byte, info_size, data_size
    output logic [2:0]       m_axis_tuser,   // status
    output logic             m_axis_tlast    // part_end
);
    import sidd_pkg::*;

    logic       take;
    logic       out_free;
    logic [7:0] cur_byte;
    logic       res_valid;
    result_t    res;
    result_t    m_res;

    sidd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid_i  (s_axis_tvalid),
        .s_ready_o  (s_axis_tready),
        .s_byte_i   (s_axis_tdata),
        .out_free_i (out_free),
        .take_o     (take),
        .byte_o     (cur_byte)
    );

    sidd_core #(
        .LEN_DIGITS (LEN_DIGITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .take_i      (take),
        .byte_i      (cur_byte),
        .res_valid_o (res_valid),
        .res_o       (res)
    );

    sidd_out_stage u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .take_i      (take),
        .res_valid_i (res_valid),
        .res_i       (res),
        .out_free_o  (out_free),
        .m_valid_o   (m_axis_tvalid),
        .m_ready_i   (m_axis_tready),
        .m_res_o     (m_res)
    );

    assign m_axis_tdata = {m_res.data_size, m_res.info_size, m_res.out_byte};
    assign m_axis_tuser = m_res.status;
    assign m_axis_tlast = m_res.part_end;

endmodule

`default_nettype wire

// ===== src/sidd_in_stage.sv =====
// Input register: holds one received byte until the core consumes it.
`timescale 1ns / 1ps
`default_nettype none

module sidd_in_stage (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid_i,
    output logic            s_ready_o,
    input  wire logic [7:0] s_byte_i,
    input  wire logic       out_free_i,
    output logic            take_o,
    output logic [7:0]      byte_o
);
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       load;

    // Stage empties whenever the result register can take its outcome
    assign take_o    = valid_reg && out_free_i;
    assign s_ready_o = !valid_reg || out_free_i;
    assign load      = s_valid_i && s_ready_o;
    assign byte_o    = byte_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (take_o) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= s_byte_i;
        end
    end

endmodule

`default_nettype wire

// ===== src/sidd_core.sv =====
// Deframer core: per-byte header decode, part counting and framing checks.
`timescale 1ns / 1ps
`default_nettype none

module sidd_core #(
    parameter int LEN_DIGITS = 6
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       take_i,
    input  wire logic [7:0] byte_i,
    output logic            res_valid_o,
    output sidd_pkg::result_t res_o
);
    import sidd_pkg::*;

    localparam int HDR_LEN  = 2 * LEN_DIGITS + 4;
    localparam int POS_W    = $clog2(HDR_LEN);
    localparam int LEN_W    = $clog2(10 ** LEN_DIGITS);
    localparam logic [POS_W-1:0] POS_INFO_END = POS_W'(2 + LEN_DIGITS);
    localparam logic [POS_W-1:0] POS_DIG_END  = POS_W'(2 + 2 * LEN_DIGITS);
    localparam logic [POS_W-1:0] POS_CLOSE    = POS_W'(HDR_LEN - 2);
    localparam logic [POS_W-1:0] POS_START    = POS_W'(2);
    localparam logic [LEN_W-1:0] MIN_LEN      = LEN_W'(4);

    phase_t           phase_reg, phase_next;
    logic [POS_W-1:0] hpos_reg, hpos_next;
    logic [LEN_W-1:0] info_len_reg, info_len_next;
    logic [LEN_W-1:0] data_len_reg, data_len_next;
    logic [LEN_W-1:0] pcount_reg, pcount_next;
    logic [7:0]       prev_reg, prev_next;

    logic [3:0]         digit;
    logic               is_digit;
    logic [LEN_W-1:0]   acc_src;
    logic [LEN_W-1:0]   acc_new;
    logic [LEN_W-1:0]   part_len;
    logic [7:0]         tag;
    logic [LEN_W:0]     pos_p1;
    logic [LEN_W:0]     pos_p2;
    logic [LEN_W:0]     len_ext;
    logic               last;
    logic               frame_ok;
    logic [LEN_W+SIZE_W-1:0] info_ext;
    logic [LEN_W+SIZE_W-1:0] data_ext;

    // Digit decode and decimal accumulate (x10 as shift-add)
    assign is_digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
    assign digit    = byte_i[3:0];
    assign acc_src  = (hpos_reg < POS_INFO_END) ? info_len_reg : data_len_reg;
    assign acc_new  = LEN_W'(acc_src << 3) + LEN_W'(acc_src << 1) + LEN_W'(digit);

    // Part position versus length
    assign part_len = (phase_reg == PH_INFO) ? info_len_reg : data_len_reg;
    assign tag      = (phase_reg == PH_INFO) ? CH_I : CH_D;
    assign pos_p1   = (LEN_W + 1)'(pcount_reg) + (LEN_W + 1)'(1);
    assign pos_p2   = (LEN_W + 1)'(pcount_reg) + (LEN_W + 1)'(2);
    assign len_ext  = {1'b0, part_len};
    assign last     = (pos_p1 >= len_ext);

    always_comb begin
        if (pcount_reg == '0) begin
            frame_ok = (byte_i == tag);
        end else if (pcount_reg == LEN_W'(1)) begin
            frame_ok = (byte_i == CH_OPEN);
        end else if (pos_p2 == len_ext) begin
            frame_ok = (byte_i == CH_CLOSE);
        end else if (pos_p1 == len_ext) begin
            frame_ok = (byte_i == tag);
        end else begin
            frame_ok = 1'b1;
        end
    end

    // Low 20 bits of the decoded lengths
    assign info_ext = {{SIZE_W{1'b0}}, info_len_reg};
    assign data_ext = {{SIZE_W{1'b0}}, data_len_reg};

    // Next state and result
    always_comb begin
        phase_next    = phase_reg;
        hpos_next     = hpos_reg;
        info_len_next = info_len_reg;
        data_len_next = data_len_reg;
        pcount_next   = pcount_reg;
        prev_next     = prev_reg;
        res_valid_o   = 1'b0;
        res_o.status    = ST_HDR_BAD;
        res_o.out_byte  = byte_i;
        res_o.part_end  = 1'b0;
        res_o.info_size = info_ext[SIZE_W-1:0];
        res_o.data_size = data_ext[SIZE_W-1:0];

        case (phase_reg)
            PH_HEADER: begin
                if (hpos_reg < POS_DIG_END) begin
                    if (!is_digit) begin
                        res_valid_o     = 1'b1;
                        res_o.info_size = '0;
                        res_o.data_size = '0;
                    end else begin
                        if (hpos_reg < POS_INFO_END) begin
                            info_len_next = acc_new;
                        end else begin
                            data_len_next = acc_new;
                        end
                        hpos_next = hpos_reg + POS_W'(1);
                    end
                end else if (hpos_reg == POS_CLOSE) begin
                    if (byte_i != CH_CLOSE) begin
                        res_valid_o     = 1'b1;
                        res_o.info_size = '0;
                        res_o.data_size = '0;
                    end else begin
                        hpos_next = hpos_reg + POS_W'(1);
                    end
                end else begin
                    if (byte_i != CH_S) begin
                        res_valid_o     = 1'b1;
                        res_o.info_size = '0;
                        res_o.data_size = '0;
                    end else if (info_len_reg < MIN_LEN) begin
                        res_valid_o  = 1'b1;
                        res_o.status = ST_INFO_BAD;
                    end else if (data_len_reg < MIN_LEN) begin
                        res_valid_o  = 1'b1;
                        res_o.status = ST_DATA_BAD;
                    end else begin
                        phase_next  = PH_INFO;
                        hpos_next   = '0;
                        pcount_next = '0;
                    end
                end
            end
            PH_INFO, PH_DATA: begin
                res_valid_o = 1'b1;
                if (!frame_ok) begin
                    res_o.status = (phase_reg == PH_INFO) ? ST_INFO_BAD : ST_DATA_BAD;
                end else begin
                    res_o.status   = (phase_reg == PH_INFO) ? ST_INFO : ST_DATA;
                    res_o.part_end = last;
                    if (!last) begin
                        pcount_next = pcount_reg + LEN_W'(1);
                    end else if (phase_reg == PH_INFO) begin
                        phase_next  = PH_DATA;
                        pcount_next = '0;
                    end
                end
            end
            default: begin
                // Hunt for the opening pair
                if (prev_reg == CH_S && byte_i == CH_OPEN) begin
                    phase_next    = PH_HEADER;
                    hpos_next     = POS_START;
                    info_len_next = '0;
                    data_len_next = '0;
                    pcount_next   = '0;
                    prev_next     = '0;
                end else begin
                    phase_next = PH_HUNT;
                    prev_next  = byte_i;
                end
            end
        endcase

        // Any corrupt result or completed message resumes the hunt
        if (res_valid_o && (res_o.status >= ST_HDR_BAD ||
                            (res_o.status == ST_DATA && res_o.part_end))) begin
            phase_next  = PH_HUNT;
            hpos_next   = '0;
            pcount_next = '0;
            prev_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HUNT;
            hpos_reg     <= '0;
            info_len_reg <= '0;
            data_len_reg <= '0;
            pcount_reg   <= '0;
            prev_reg     <= '0;
        end else if (take_i) begin
            phase_reg    <= phase_next;
            hpos_reg     <= hpos_next;
            info_len_reg <= info_len_next;
            data_len_reg <= data_len_next;
            pcount_reg   <= pcount_next;
            prev_reg     <= prev_next;
        end
    end

    // Header position stays inside the header while collecting it
    a_hpos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_HEADER |-> (hpos_reg >= POS_START &&
                                    hpos_reg <= POS_W'(HDR_LEN - 1)))
        else $error("header position out of range");

    // Part counter never reaches the part length
    a_pcount_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_INFO || phase_reg == PH_DATA) |-> pcount_reg < part_len)
        else $error("part counter past part length");

    // A corrupt result sends the deframer back to hunting
    a_bad_hunts: assert property (@(posedge aclk) disable iff (!aresetn)
        take_i && res_valid_o && res_o.status >= ST_HDR_BAD |=>
            phase_reg == PH_HUNT && prev_reg == '0)
        else $error("corrupt result did not resume the hunt");

    // End marker only on good part bytes
    a_end_good: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid_o && res_o.part_end |-> (res_o.status == ST_INFO ||
                                           res_o.status == ST_DATA))
        else $error("part end on a corrupt result");

    // Last info byte hands over to the data part
    a_info_to_data: assert property (@(posedge aclk) disable iff (!aresetn)
        take_i && res_valid_o && res_o.status == ST_INFO && res_o.part_end |=>
            phase_reg == PH_DATA && pcount_reg == '0)
        else $error("info part end did not start data part");

endmodule

`default_nettype wire

// ===== src/sidd_out_stage.sv =====
// Result register: holds one result transaction until the sink takes it.
`timescale 1ns / 1ps
`default_nettype none

module sidd_out_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              take_i,
    input  wire logic              res_valid_i,
    input  wire sidd_pkg::result_t res_i,
    output logic                   out_free_o,
    output logic                   m_valid_o,
    input  wire logic              m_ready_i,
    output sidd_pkg::result_t      m_res_o
);
    import sidd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_free_o = !valid_reg || m_ready_i;
    assign m_valid_o  = valid_reg;
    assign m_res_o    = res_reg;

    // Valid loads on every consumed byte; a byte without a result leaves it empty
    always_comb begin
        valid_next = valid_reg;
        if (take_i) begin
            valid_next = res_valid_i;
        end else if (m_ready_i) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_i && res_valid_i) begin
            res_reg <= res_i;
        end
    end

endmodule

`default_nettype wire
